// File: hdl/hte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTML text extractor package
// Shared types, register constants and character helpers of the extractor.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int unsigned CFG_BITS  = 24;
    localparam int unsigned FIELD_BITS = 24;

    localparam logic [CFG_BITS-1:0] MIN_TEXT_RESET = 24'd800;
    localparam logic [CFG_BITS-1:0] MAX_TEXT_RESET = 24'd25000;

    localparam logic CFG_MIN_TEXT = 1'b0;
    localparam logic CFG_MAX_TEXT = 1'b1;

    localparam logic [3:0] SCRIPT_CLOSE_LEN = 4'd9;
    localparam logic [3:0] STYLE_CLOSE_LEN  = 4'd8;

    typedef enum logic [4:0] {
        MODE_TEXT    = 5'b00001,
        MODE_TAG     = 5'b00010,
        MODE_SCRIPT  = 5'b00100,
        MODE_STYLE   = 5'b01000,
        MODE_COMMENT = 5'b10000
    } parse_mode_t;

    typedef struct packed {
        logic [7:0]            text_byte;
        logic                  text_valid;
        logic                  summary_valid;
        logic [FIELD_BITS-1:0] text_length;
        logic [FIELD_BITS-1:0] paragraphs;
        logic                  accepted;
        logic                  last_result;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] script_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "<";
            4'd1:    ch = "/";
            4'd2:    ch = "s";
            4'd3:    ch = "c";
            4'd4:    ch = "r";
            4'd5:    ch = "i";
            4'd6:    ch = "p";
            4'd7:    ch = "t";
            4'd8:    ch = ">";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] style_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "<";
            4'd1:    ch = "/";
            4'd2:    ch = "s";
            4'd3:    ch = "t";
            4'd4:    ch = "y";
            4'd5:    ch = "l";
            4'd6:    ch = "e";
            4'd7:    ch = ">";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: hdl/html_text_extractor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTML text extractor
// Strips tags, script, style and comments from an HTML byte stream, folds
// whitespace and emits the plain text followed by a per-document summary.
// ----------------------------------------------------------------------------
// The block takes one HTML byte per cycle while s_ready is high. Each byte is
// parsed in the cycle it is accepted and its results, a text beat and on the
// final byte a summary beat, go into a four-entry result queue. The input is
// ready while the queue has room for two beats, so a steady stream that yields
// at most one beat per byte runs at one byte per cycle while the output keeps
// up; a final byte that yields two beats may stall the input when the output
// side stalls. The first result appears the cycle after its byte is accepted.
module html_text_extractor_unit #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_end_of_doc,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_text_byte,
    output logic             m_text_valid,
    output logic             m_summary_valid,
    output logic [23:0]      m_text_length,
    output logic [23:0]      m_paragraphs,
    output logic             m_accepted,
    output logic             m_last_result
);

    localparam int unsigned CW = (COUNT_BITS > hte_pkg::CFG_BITS) ? COUNT_BITS
                                                                   : hte_pkg::CFG_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [hte_pkg::CFG_BITS-1:0] min_len_reg;
    logic [hte_pkg::CFG_BITS-1:0] max_len_reg;

    hte_pkg::parse_mode_t mode_reg, mode_next;
    logic                 space_reg, space_next;
    logic [7:0]           prefix_reg [0:5];
    logic [7:0]           prefix_next [0:5];
    logic [2:0]           tag_len_reg, tag_len_next;
    logic [3:0]           close_reg, close_next;
    logic [COUNT_BITS-1:0] text_cnt_reg, text_cnt_next, text_cnt_calc;
    logic [COUNT_BITS-1:0] para_cnt_reg, para_cnt_next, para_cnt_calc;

    logic                 produce;
    logic [7:0]           prod_char;
    logic                 emit_ok;
    logic                 has_text;
    logic                 para_tag;
    logic                 block_tag;
    logic [3:0]           match_len;
    logic [7:0]           lc;
    logic [CW-1:0]        cnt_ext;
    logic [CW-1:0]        para_ext;
    hte_pkg::result_t     text_res;
    hte_pkg::result_t     sum_res;

    hte_pkg::result_t     q_reg [0:3];
    logic [1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [2:0]           count_reg;
    logic                 in_fire;
    logic                 out_fire;
    logic                 push0, push1;
    hte_pkg::result_t     slot0;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= hte_pkg::MIN_TEXT_RESET;
            max_len_reg <= hte_pkg::MAX_TEXT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == hte_pkg::CFG_MIN_TEXT) begin
                min_len_reg <= pwdata[hte_pkg::CFG_BITS-1:0];
            end else begin
                max_len_reg <= pwdata[hte_pkg::CFG_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == hte_pkg::CFG_MIN_TEXT) begin
            prdata = {8'd0, min_len_reg};
        end else begin
            prdata = {8'd0, max_len_reg};
        end
    end

    // Byte parser.
    assign lc = hte_pkg::to_lower(s_in_byte);

    always_comb begin
        mode_next     = mode_reg;
        space_next    = space_reg;
        prefix_next   = prefix_reg;
        tag_len_next  = tag_len_reg;
        close_next    = close_reg;
        text_cnt_calc = text_cnt_reg;
        para_cnt_calc = para_cnt_reg;
        produce       = 1'b0;
        prod_char     = " ";
        para_tag      = 1'b0;
        block_tag     = 1'b0;
        match_len     = 4'd0;
        case (mode_reg)
            hte_pkg::MODE_TAG: begin
                if (s_in_byte == ">") begin
                    mode_next = hte_pkg::MODE_TEXT;
                    if (tag_len_reg >= 3'd6 && prefix_reg[0] == "s" && prefix_reg[1] == "c"
                        && prefix_reg[2] == "r" && prefix_reg[3] == "i"
                        && prefix_reg[4] == "p" && prefix_reg[5] == "t") begin
                        mode_next  = hte_pkg::MODE_SCRIPT;
                        close_next = 4'd0;
                    end else if (tag_len_reg >= 3'd5 && prefix_reg[0] == "s"
                                 && prefix_reg[1] == "t" && prefix_reg[2] == "y"
                                 && prefix_reg[3] == "l" && prefix_reg[4] == "e") begin
                        mode_next  = hte_pkg::MODE_STYLE;
                        close_next = 4'd0;
                    end else begin
                        para_tag  = (tag_len_reg == 3'd2) && prefix_reg[0] == "/"
                                    && prefix_reg[1] == "p";
                        block_tag = para_tag
                                    || ((tag_len_reg == 3'd4) && prefix_reg[0] == "/"
                                        && prefix_reg[1] == "d" && prefix_reg[2] == "i"
                                        && prefix_reg[3] == "v")
                                    || ((tag_len_reg == 3'd2) && prefix_reg[0] == "b"
                                        && prefix_reg[1] == "r");
                        produce   = block_tag && !space_reg;
                        if (para_tag && para_cnt_reg != COUNT_MAX) begin
                            para_cnt_calc = para_cnt_reg + 1'b1;
                        end
                    end
                end else begin
                    if (tag_len_reg < 3'd6) begin
                        prefix_next[tag_len_reg] = lc;
                    end
                    if (tag_len_reg < 3'd7) begin
                        tag_len_next = tag_len_reg + 1'b1;
                    end
                    if (tag_len_next == 3'd3 && prefix_next[0] == "!" && prefix_next[1] == "-"
                        && prefix_next[2] == "-") begin
                        mode_next  = hte_pkg::MODE_COMMENT;
                        close_next = 4'd0;
                    end
                end
            end
            hte_pkg::MODE_SCRIPT: begin
                if (hte_pkg::script_char(close_reg) == lc) begin
                    match_len = close_reg + 1'b1;
                end else begin
                    match_len = (lc == "<") ? 4'd1 : 4'd0;
                end
                if (match_len == hte_pkg::SCRIPT_CLOSE_LEN) begin
                    close_next = 4'd0;
                    mode_next  = hte_pkg::MODE_TEXT;
                end else begin
                    close_next = match_len;
                end
            end
            hte_pkg::MODE_STYLE: begin
                if (hte_pkg::style_char(close_reg) == lc) begin
                    match_len = close_reg + 1'b1;
                end else begin
                    match_len = (lc == "<") ? 4'd1 : 4'd0;
                end
                if (match_len == hte_pkg::STYLE_CLOSE_LEN) begin
                    close_next = 4'd0;
                    mode_next  = hte_pkg::MODE_TEXT;
                end else begin
                    close_next = match_len;
                end
            end
            hte_pkg::MODE_COMMENT: begin
                if (s_in_byte == "-") begin
                    close_next = (close_reg >= 4'd1) ? 4'd2 : 4'd1;
                end else if (s_in_byte == ">" && close_reg >= 4'd2) begin
                    close_next = 4'd0;
                    mode_next  = hte_pkg::MODE_TEXT;
                end else begin
                    close_next = 4'd0;
                end
            end
            default: begin
                if (s_in_byte == "<") begin
                    mode_next    = hte_pkg::MODE_TAG;
                    tag_len_next = 3'd0;
                end else if (hte_pkg::is_space(s_in_byte)) begin
                    produce = !space_reg;
                end else begin
                    produce   = 1'b1;
                    prod_char = s_in_byte;
                end
            end
        endcase

        emit_ok = CW'(text_cnt_reg) < CW'(max_len_reg);
        if (produce) begin
            space_next = (prod_char == " ");
            if (text_cnt_reg != COUNT_MAX) begin
                text_cnt_calc = text_cnt_reg + 1'b1;
            end
        end
        has_text = produce && emit_ok;

        text_cnt_next = text_cnt_calc;
        para_cnt_next = para_cnt_calc;
        if (s_end_of_doc) begin
            mode_next     = hte_pkg::MODE_TEXT;
            space_next    = 1'b0;
            tag_len_next  = 3'd0;
            close_next    = 4'd0;
            text_cnt_next = '0;
            para_cnt_next = '0;
        end
    end

    assign cnt_ext  = CW'(text_cnt_calc);
    assign para_ext = CW'(para_cnt_calc);

    always_comb begin
        text_res               = '0;
        text_res.text_byte     = prod_char;
        text_res.text_valid    = 1'b1;
        text_res.last_result   = !s_end_of_doc;

        sum_res                = '0;
        sum_res.summary_valid  = 1'b1;
        sum_res.text_length    = cnt_ext[23:0];
        sum_res.paragraphs     = para_ext[23:0];
        sum_res.accepted       = cnt_ext >= CW'(min_len_reg);
        sum_res.last_result    = 1'b1;
    end

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign push0    = in_fire && (has_text || s_end_of_doc);
    assign push1    = in_fire && has_text && s_end_of_doc;
    assign slot0    = has_text ? text_res : sum_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= hte_pkg::MODE_TEXT;
            space_reg    <= 1'b0;
            tag_len_reg  <= 3'd0;
            close_reg    <= 4'd0;
            text_cnt_reg <= '0;
            para_cnt_reg <= '0;
        end else if (in_fire) begin
            mode_reg     <= mode_next;
            space_reg    <= space_next;
            tag_len_reg  <= tag_len_next;
            close_reg    <= close_next;
            text_cnt_reg <= text_cnt_next;
            para_cnt_reg <= para_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            prefix_reg <= prefix_next;
        end
    end

    // Result queue.
    always_ff @(posedge aclk) begin
        if (push0) begin
            q_reg[wr_ptr_reg] <= slot0;
        end
        if (push1) begin
            q_reg[wr_ptr_reg + 2'd1] <= sum_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + 2'(push0) + 2'(push1);
            rd_ptr_reg <= rd_ptr_reg + 2'(out_fire);
            count_reg  <= count_reg + 3'(push0) + 3'(push1) - 3'(out_fire);
        end
    end

    assign s_ready         = (count_reg <= 3'd2);
    assign m_valid         = (count_reg != 3'd0);
    assign m_text_byte     = q_reg[rd_ptr_reg].text_byte;
    assign m_text_valid    = q_reg[rd_ptr_reg].text_valid;
    assign m_summary_valid = q_reg[rd_ptr_reg].summary_valid;
    assign m_text_length   = q_reg[rd_ptr_reg].text_length;
    assign m_paragraphs    = q_reg[rd_ptr_reg].paragraphs;
    assign m_accepted      = q_reg[rd_ptr_reg].accepted;
    assign m_last_result   = q_reg[rd_ptr_reg].last_result;

endmodule
`default_nettype wire
